>>> design/mmt_pkg.sv
// Shared types and constants for the MAC mask table.
// Depends on nothing; mac_mask_table and the testbench import it.
package mmt_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int MAC_W       = 48;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int DIR_W       = 8;
  localparam int STAT_W      = 4;

  localparam logic [DIR_W-1:0] DIR_NOP = 8'd0;
  localparam logic [DIR_W-1:0] DIR_ADD = 8'd1;
  localparam logic [DIR_W-1:0] DIR_DEL = 8'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED   = 4'd0,
    ST_PRESENT = 4'd1,
    ST_REMOVED = 4'd2,
    ST_ABSENT  = 4'd3,
    ST_FULL    = 4'd4,
    ST_BAD     = 4'd5,
    ST_SKIPPED = 4'd6,
    ST_NOP     = 4'd7,
    ST_LIST    = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_REPLY,
    S_LIST
  } fsm_t;

  typedef struct packed {
    logic             command;
    logic [DIR_W-1:0] directive;
    logic [MAC_W-1:0] mac;
    logic             last_in_packet;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [MAC_W-1:0] entry_mac;
    logic [IDX_W-1:0] entry_index;
    logic             entry_valid;
    logic [CNT_W-1:0] entry_count;
    logic             last;
  } out_word_t;

endpackage

>>> design/mac_mask_table.sv
// MAC mask table: ordered list of up to 32 MAC addresses, edited by directives.
// Nop, bad and skipped words go straight to the status word; add and delete first walk the
// RAM, one read a cycle, delete shift included. A list of the entries follows the status word
// when the packet ends clean, or follows at once when a read command is accepted.
// One word in flight, next accepted at the edge taking the final word; no result stall.
// Sync reset empties the table and clears the fail flag. Depends on mmt_pkg and mmt_ram.
module mac_mask_table
  import mmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  request,
  output logic      strobe,
  output out_word_t result
);

  fsm_t             state, state_next;
  in_word_t         req_q;
  logic [CNT_W-1:0] total, total_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic             pend, pend_next;
  logic [IDX_W-1:0] pend_idx;
  logic             failed, failed_next;
  status_t          stat_q, stat_next;
  out_word_t        result_next;
  logic             strobe_next;

  // RAM port
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [MAC_W-1:0] wdata, rdata;

  logic accept, hit, more, do_list, list_last;

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  // pend marks that rdata holds the entry at pend_idx, read last cycle
  assign hit       = pend && (rdata == req_q.mac);
  assign more      = (rd_idx < total);
  // the list follows a packet's last directive only if the packet stayed clean
  assign do_list   = req_q.last_in_packet && !failed;
  assign list_last = ({1'b0, pend_idx} + CNT_W'(1)) == total;

  mmt_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (MAC_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (request.command) begin
            state_next = S_LIST;
          end else if (failed) begin
            state_next = S_REPLY;
          end else if (request.directive == DIR_ADD || request.directive == DIR_DEL) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_REPLY;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = (req_q.directive == DIR_DEL) ? S_SHIFT : S_REPLY;
        end else if (!pend && !more) begin
          state_next = S_REPLY;
        end
      end
      S_SHIFT: begin
        if (!pend && !more) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        state_next = do_list ? S_LIST : S_IDLE;
      end
      S_LIST: begin
        if (total == '0) begin
          state_next = S_IDLE;
        end else if (pend && list_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath, RAM control and result word
  always_comb begin
    rd_idx_next = rd_idx;
    pend_next   = 1'b0;
    total_next  = total;
    failed_next = failed;
    stat_next   = stat_q;
    re          = 1'b0;
    raddr       = rd_idx[IDX_W-1:0];
    we          = 1'b0;
    waddr       = pend_idx - IDX_W'(1);
    wdata       = rdata;
    strobe_next = 1'b0;
    result_next = '{status: ST_LIST, entry_mac: '0, entry_index: '0,
                    entry_valid: 1'b0, entry_count: total, last: 1'b0};
    case (state)
      S_IDLE: begin
        if (accept) begin
          rd_idx_next = '0;
          if (request.command) begin
            failed_next = 1'b0;
          end else if (failed) begin
            stat_next = ST_SKIPPED;
          end else begin
            case (request.directive)
              DIR_NOP: stat_next = ST_NOP;
              DIR_ADD: stat_next = ST_ADDED;
              DIR_DEL: stat_next = ST_ABSENT;
              default: begin
                stat_next   = ST_BAD;
                failed_next = 1'b1;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        // linear search, one read issued per cycle, compared in the next cycle
        re        = more && !hit;
        pend_next = re;
        if (re) begin
          rd_idx_next = rd_idx + CNT_W'(1);
        end
        if (hit) begin
          if (req_q.directive == DIR_DEL) begin
            rd_idx_next = {1'b0, pend_idx} + CNT_W'(1);
          end else begin
            stat_next = ST_PRESENT;
          end
        end else if (!pend && !more) begin
          if (req_q.directive == DIR_ADD) begin
            if (total >= CNT_W'(MAX_ENTRIES)) begin
              stat_next   = ST_FULL;
              failed_next = 1'b1;
            end else begin
              we         = 1'b1;
              waddr      = total[IDX_W-1:0];
              wdata      = req_q.mac;
              total_next = total + CNT_W'(1);
              stat_next  = ST_ADDED;
            end
          end else begin
            stat_next = ST_ABSENT;
          end
        end
      end
      S_SHIFT: begin
        // read i, write it back at i-1; writes trail reads so no overlap
        re        = more;
        pend_next = re;
        if (re) begin
          rd_idx_next = rd_idx + CNT_W'(1);
        end
        if (pend) begin
          we = 1'b1;
        end
        if (!pend && !more) begin
          total_next = total - CNT_W'(1);
          stat_next  = ST_REMOVED;
        end
      end
      S_REPLY: begin
        strobe_next        = 1'b1;
        result_next.status = stat_q;
        result_next.last   = !do_list;
        rd_idx_next        = '0;
        if (req_q.last_in_packet) begin
          failed_next = 1'b0;
        end
      end
      S_LIST: begin
        if (total == '0) begin
          strobe_next      = 1'b1;
          result_next.last = 1'b1;
        end else begin
          re        = more;
          pend_next = re;
          if (re) begin
            rd_idx_next = rd_idx + CNT_W'(1);
          end
          if (pend) begin
            strobe_next             = 1'b1;
            result_next.entry_mac   = rdata;
            result_next.entry_index = pend_idx;
            result_next.entry_valid = 1'b1;
            result_next.last        = list_last;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      total  <= '0;
      failed <= 1'b0;
      pend   <= 1'b0;
      rd_idx <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      total  <= total_next;
      failed <= failed_next;
      pend   <= pend_next;
      rd_idx <= rd_idx_next;
      strobe <= strobe_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
    if (re) begin
      pend_idx <= raddr;
    end
    stat_q <= stat_next;
    result <= result_next;
  end

  // Checks
  a_total_bound : assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_pend_state : assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SCAN || state == S_SHIFT || state == S_LIST))
    else $error("read data pending outside a table walk");

  a_entry_index : assert property (@(posedge clk) disable iff (rst)
    (strobe && result.entry_valid) |-> ({1'b0, result.entry_index} < result.entry_count))
    else $error("listed entry beyond entry count");

  a_no_write_idle : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_REPLY || state == S_LIST) |-> !we)
    else $error("table written outside an edit");

endmodule

>>> design/mmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmt_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/testbench.sv
// Self-checking bench for mac_mask_table: directed table of words, then random edit packets, reads and noise.
// A local model of the address list predicts every result word; the checker compares by field.
// Depends on mmt_pkg and the mac_mask_table RTL.
module testbench;
  import mmt_pkg::*;

  // Command and directive codes not named in the package
  localparam logic            CMD_EDIT    = 1'b0;
  localparam logic            CMD_READ    = 1'b1;
  localparam logic [DIR_W-1:0] DIR_BAD_LOW = 8'd3;    // lowest undefined code
  localparam logic [DIR_W-1:0] DIR_BAD_MSB = 8'h80;
  localparam logic [DIR_W-1:0] DIR_BAD_TOP = 8'hFF;

  localparam int RANDOM_WORDS = 230;
  localparam int SETTLE_CYCLES = 80;   // longest walk plus a full list, with margin

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  request = '0;
  logic      strobe;
  out_word_t result;

  mac_mask_table i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop, far beyond the slowest legal run (~300 words)
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Address list model: contents, occupancy and the packet-failed flag
  // ---------------------------------------------------------------------------
  logic [MAC_W-1:0] acl_mac [MAX_ENTRIES];
  int               acl_count  = 0;
  bit               acl_failed = 1'b0;
  int               acl_peak   = 0;
  int               full_hits  = 0;
  out_word_t        expected_q [$];

  function automatic int acl_find(logic [MAC_W-1:0] mac);
    for (int i = 0; i < acl_count; i++)
      if (acl_mac[i] == mac) return i;
    return -1;
  endfunction

  // Whole list in table order; an empty table gives one invalid entry
  function automatic void acl_list_out();
    out_word_t r;
    r = '0;
    r.status      = ST_LIST;
    r.entry_count = CNT_W'(acl_count);
    if (acl_count == 0) begin
      r.last = 1'b1;
      expected_q.push_back(r);
      return;
    end
    for (int i = 0; i < acl_count; i++) begin
      r.entry_mac   = acl_mac[i];
      r.entry_index = IDX_W'(i);
      r.entry_valid = 1'b1;
      r.last        = (i == acl_count - 1);
      expected_q.push_back(r);
    end
  endfunction

  function automatic void acl_apply(in_word_t w);
    status_t   st;
    int        pos;
    bit        show;
    out_word_t r;
    if (w.command == CMD_READ) begin
      // read ignores the other fields and clears a pending failure
      acl_failed = 1'b0;
      acl_list_out();
      return;
    end
    if (acl_failed) begin
      st = ST_SKIPPED;
    end else begin
      case (w.directive)
        DIR_NOP: st = ST_NOP;
        DIR_ADD: begin
          if (acl_find(w.mac) >= 0) st = ST_PRESENT;
          else if (acl_count >= MAX_ENTRIES) st = ST_FULL;
          else begin
            acl_mac[acl_count] = w.mac;
            acl_count++;
            st = ST_ADDED;
          end
        end
        DIR_DEL: begin
          pos = acl_find(w.mac);
          if (pos < 0) st = ST_ABSENT;
          else begin
            for (int i = pos; i < acl_count - 1; i++) acl_mac[i] = acl_mac[i+1];
            acl_count--;
            st = ST_REMOVED;
          end
        end
        default: st = ST_BAD;
      endcase
      if (st == ST_FULL || st == ST_BAD) acl_failed = 1'b1;
    end
    if (st == ST_FULL) full_hits++;
    if (acl_count > acl_peak) acl_peak = acl_count;
    show = w.last_in_packet && !acl_failed;
    if (w.last_in_packet) acl_failed = 1'b0;
    r = '0;
    r.status      = st;
    r.entry_count = CNT_W'(acl_count);
    r.last        = !show;
    expected_q.push_back(r);
    if (show) acl_list_out();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobed word against the oldest expectation
  // ---------------------------------------------------------------------------
  int mismatches = 0;
  int results_checked = 0;

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_word_t exp;
    if (!rst && strobe) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word, status %0d", result.status);
        mismatches++;
      end else begin
        exp = expected_q.pop_front();
        results_checked++;
        check_field("status",      exp.status,      result.status);
        check_field("entry_mac",   exp.entry_mac,   result.entry_mac);
        check_field("entry_index", exp.entry_index, result.entry_index);
        check_field("entry_valid", exp.entry_valid, result.entry_valid);
        check_field("entry_count", exp.entry_count, result.entry_count);
        check_field("last",        exp.last,        result.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back words, random gaps between bursts
  // ---------------------------------------------------------------------------
  int words_sent = 0;
  int burst_left = 4;

  // Typed rows replace the model's first result status and count with hand values
  task automatic send_word(in_word_t w, bit typed = 1'b0, status_t st = ST_NOP,
                           int cnt = 0);
    int        first;
    out_word_t r;
    request <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    // accepted at this edge
    words_sent++;
    first = expected_q.size();
    acl_apply(w);
    if (typed) begin
      r = expected_q[first];
      r.status      = st;
      r.entry_count = CNT_W'(cnt);
      expected_q[first] = r;
    end
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      // now and then a long unbroken run
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  function automatic in_word_t edit_word(logic [DIR_W-1:0] dir, logic [MAC_W-1:0] mac,
                                         bit lip);
    in_word_t w;
    w.command        = CMD_EDIT;
    w.directive      = dir;
    w.mac            = mac;
    w.last_in_packet = lip;
    return w;
  endfunction

  // Either a stored address or a fresh random one
  function automatic logic [MAC_W-1:0] pick_mac(bit stored);
    logic [63:0] raw;
    if (stored && acl_count > 0) return acl_mac[$urandom_range(0, acl_count - 1)];
    raw = {$urandom, $urandom};
    return raw[MAC_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t w;
    bit       typed;
    status_t  st;
    int       cnt;
  } stim_row_t;

  stim_row_t plan [$];

  function automatic stim_row_t stim(logic cmd, logic [DIR_W-1:0] dir, logic [MAC_W-1:0] mac,
                                     bit lip, bit typed, status_t st, int cnt);
    stim_row_t s;
    s.w       = edit_word(dir, mac, lip);
    s.w.command = cmd;
    s.typed   = typed;
    s.st      = st;
    s.cnt     = cnt;
    return s;
  endfunction

  initial begin : stimulus
    in_word_t    w;
    int          len, pick, mode;
    bit          filled;
    logic [95:0] noise;

    filled = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // read of an empty table, delete absent, nop closing a packet
    plan.push_back(stim(CMD_READ, DIR_NOP, '0, 0, 1, ST_LIST,    0));
    plan.push_back(stim(CMD_EDIT, DIR_DEL, '0, 0, 1, ST_ABSENT,  0));
    plan.push_back(stim(CMD_EDIT, DIR_NOP, '0, 1, 1, ST_NOP,     0));
    // extreme addresses, duplicate add, list on packet end
    plan.push_back(stim(CMD_EDIT, DIR_ADD, '0,             0, 1, ST_ADDED,   1));
    plan.push_back(stim(CMD_EDIT, DIR_ADD, 48'hFFFF_FFFF_FFFF, 0, 1, ST_ADDED,   2));
    plan.push_back(stim(CMD_EDIT, DIR_ADD, '0,             0, 1, ST_PRESENT, 2));
    plan.push_back(stim(CMD_EDIT, DIR_ADD, 48'hAAAA_AAAA_AAAA, 1, 1, ST_ADDED,   3));
    // unknown address on delete is not a failure
    plan.push_back(stim(CMD_EDIT, DIR_DEL, 48'h5555_5555_5555, 0, 1, ST_ABSENT,  3));
    // bad code: rest of packet skipped, no list, flag cleared at packet end
    plan.push_back(stim(CMD_EDIT, DIR_BAD_TOP, '0,         0, 1, ST_BAD,     3));
    plan.push_back(stim(CMD_EDIT, DIR_ADD, 48'h1234_5678_9ABC, 0, 1, ST_SKIPPED, 3));
    plan.push_back(stim(CMD_EDIT, DIR_DEL, '0,             1, 1, ST_SKIPPED, 3));
    // first entry removed, the rest shift down
    plan.push_back(stim(CMD_EDIT, DIR_DEL, '0,             1, 1, ST_REMOVED, 2));
    plan.push_back(stim(CMD_EDIT, DIR_BAD_LOW, '0,         1, 1, ST_BAD,     2));
    plan.push_back(stim(CMD_EDIT, DIR_BAD_MSB, '0,         0, 1, ST_BAD,     2));
    // read with junk fields clears the pending failure
    plan.push_back(stim(CMD_READ, DIR_BAD_TOP, 48'h5555_5555_5555, 0, 0, ST_NOP, 0));
    plan.push_back(stim(CMD_EDIT, DIR_ADD, 48'h5555_5555_5555, 1, 1, ST_ADDED,   3));
    plan.push_back(stim(CMD_EDIT, DIR_DEL, 48'hFFFF_FFFF_FFFF, 0, 1, ST_REMOVED, 2));
    plan.push_back(stim(CMD_EDIT, DIR_NOP, 48'hFFFF_FFFF_FFFF, 0, 1, ST_NOP,     2));
    plan.push_back(stim(CMD_EDIT, DIR_DEL, 48'h5555_5555_5555, 1, 0, ST_NOP,     0));

    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].st, plan[i].cnt);

    // Random part: mostly well-formed packets, some noise and reads
    while (words_sent < RANDOM_WORDS) begin
      mode = $urandom_range(0, 99);
      if (mode < 6) begin
        // read, other fields random
        noise = {$urandom, $urandom, $urandom};
        w = noise[$bits(in_word_t)-1:0];
        w.command = CMD_READ;
        send_word(w);
      end else if (mode < 10) begin
        // raw noise: anything the fields allow
        noise = {$urandom, $urandom, $urandom};
        w = noise[$bits(in_word_t)-1:0];
        send_word(w);
      end else if (mode < 14 && !filled && words_sent > 60) begin
        // fill to capacity, overflow, then skipped tail of the same packet
        filled = 1'b1;
        // close any packet left open, so a stale failure cannot skip the fill
        send_word(edit_word(DIR_NOP, pick_mac(0), 1));
        while (acl_count < MAX_ENTRIES) send_word(edit_word(DIR_ADD, pick_mac(0), 0));
        send_word(edit_word(DIR_ADD, pick_mac(0), 0));
        send_word(edit_word(DIR_DEL, pick_mac(1), 1));
        send_word(edit_word(DIR_ADD, pick_mac(1), 1));
        // drain to empty in random order, list of an empty table at the end
        while (acl_count > 1) send_word(edit_word(DIR_DEL, pick_mac(1), 0));
        send_word(edit_word(DIR_DEL, pick_mac(1), 1));
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 6)
            w = edit_word(DIR_W'($urandom_range(DIR_BAD_LOW, DIR_BAD_TOP)), pick_mac(0), 0);
          else if (pick < 16)
            w = edit_word(DIR_NOP, pick_mac(0), 0);
          else if (pick < 62)
            w = edit_word(DIR_ADD, pick_mac($urandom_range(0, 3) == 0), 0);
          else
            w = edit_word(DIR_DEL, pick_mac($urandom_range(0, 9) < 7), 0);
          // a few packets are left open and run into the next one
          w.last_in_packet = (k == len - 1) && ($urandom_range(0, 9) != 0);
          send_word(w);
        end
      end
    end

    if (start) start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words, checked %0d result words.", words_sent, results_checked);
    $display("Table peaked at %0d of %0d entries; %0d adds refused as full.",
             acl_peak, MAX_ENTRIES, full_hits);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
